/* rtl/tkre_pkg.sv */
// ----------------------------------------------------------------------------
// tkre_pkg
// Types, constants and helpers shared by the keyword/run-length text expander.
// ----------------------------------------------------------------------------
package tkre_pkg;

    localparam int DICT_WORDS  = 157;
    localparam int WORD_LEN    = 8;
    localparam int MAX_EMIT    = 8;
    localparam int EMIT_LIMIT  = (WORD_LEN < MAX_EMIT) ? WORD_LEN : MAX_EMIT;
    localparam int POS_W       = $clog2(EMIT_LIMIT);
    localparam int STORE_DEPTH = DICT_WORDS * WORD_LEN;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DW_W        = $clog2(DICT_WORDS + 1);
    localparam int WL_W        = $clog2(WORD_LEN + 1);

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] NUL_CODE       = 8'd0;
    localparam logic [7:0] TAB_CODE       = 8'd9;
    localparam logic [7:0] LF_CODE        = 8'd10;
    localparam logic [7:0] EOT_CODE       = 8'd26;
    localparam logic [7:0] SPACE_CODE     = 8'd32;
    localparam logic [7:0] TILDE_CODE     = 8'd126;
    localparam logic [7:0] END_MARK       = 8'd124;
    localparam logic [7:0] HIGH_TOKEN     = 8'd127;
    localparam logic [7:0] HIGH_OFFSET    = 8'd99;
    localparam logic [7:0] LOW_TOKEN_END  = 8'd8;
    localparam logic [7:0] MID_TOKEN_END  = 8'd25;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
        logic [7:0] word_index;
        logic [2:0] char_pos;
        logic [7:0] dict_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic [7:0] repeat_res;
        logic       cr_before;
        logic       end_of_text;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_EMIT  = 2'd1,
        CMD_WORD  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        ch;
        logic [7:0]        rep;
        logic              cr;
        logic              eot;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [ADDR_W-1:0] word_base(input logic [7:0] word);
        word_base = ADDR_W'(word) * ADDR_W'(WORD_LEN);
    endfunction

endpackage

/* rtl/tkre_front.sv */
// ----------------------------------------------------------------------------
// tkre_front
// Accepts input items, tracks the run phase and turns items, where needed, into a
// command for the back end: a store write, a single result or a word lookup.
// ----------------------------------------------------------------------------
module tkre_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tkre_pkg::t_in_item i_in_data,
    input  tkre_pkg::t_q_status i_q_status,
    output logic               o_push,
    output tkre_pkg::t_cmd     o_cmd
);
    import tkre_pkg::*;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'b001,
        PH_COUNT  = 3'b010,
        PH_CHAR   = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_run_len, n_run_len;
    logic       accept;
    logic       push_req;
    logic [7:0] c;
    logic [7:0] word;

    assign c          = i_in_data.in_byte;
    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign o_push     = accept && push_req;

    always_comb begin
        if (c >= HIGH_TOKEN) begin
            word = c - HIGH_OFFSET;
        end else if (c <= LOW_TOKEN_END) begin
            word = c - 8'd1;
        end else if (c <= MID_TOKEN_END) begin
            word = c - 8'd3;
        end else begin
            word = c - 8'd4;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_run_len = r_run_len;
        push_req  = 1'b0;
        o_cmd     = '{kind: CMD_EMIT, addr: '0, ch: c, rep: 8'd1, cr: 1'b0, eot: 1'b0};
        if (i_in_data.mode) begin
            if ((DW_W'(i_in_data.word_index) < DW_W'(DICT_WORDS)) &&
                (WL_W'(i_in_data.char_pos) < WL_W'(WORD_LEN))) begin
                push_req   = 1'b1;
                o_cmd.kind = CMD_WRITE;
                o_cmd.addr = word_base(i_in_data.word_index) + ADDR_W'(i_in_data.char_pos);
                o_cmd.ch   = i_in_data.dict_char;
            end
        end else begin
            unique case (r_phase)
                PH_COUNT: begin
                    n_run_len = c;
                    n_phase   = PH_CHAR;
                end
                PH_CHAR: begin
                    n_phase   = PH_NORMAL;
                    push_req  = (r_run_len != 8'd0);
                    o_cmd.rep = r_run_len;
                    o_cmd.cr  = (c == LF_CODE);
                    o_cmd.eot = (c == EOT_CODE);
                end
                default: begin
                    n_phase = PH_NORMAL;
                    if ((c >= SPACE_CODE && c <= TILDE_CODE) || c == TAB_CODE) begin
                        push_req = 1'b1;
                    end else if (c == LF_CODE) begin
                        push_req = 1'b1;
                        o_cmd.cr = 1'b1;
                    end else if (c == EOT_CODE) begin
                        push_req  = 1'b1;
                        o_cmd.eot = 1'b1;
                    end else if (c == NUL_CODE) begin
                        n_phase = PH_COUNT;
                    end else if (DW_W'(word) < DW_W'(DICT_WORDS)) begin
                        push_req   = 1'b1;
                        o_cmd.kind = CMD_WORD;
                        o_cmd.addr = word_base(word);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_NORMAL;
            r_run_len <= 8'd0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_run_len <= n_run_len;
        end
    end

endmodule

/* rtl/tkre_fifo.sv */
// ----------------------------------------------------------------------------
// tkre_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tkre_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tkre_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output tkre_pkg::t_cmd      o_cmd,
    output tkre_pkg::t_q_status o_status
);
    import tkre_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_cmd           = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == Q_CNT_W'(0));
    assign o_status.full   = (r_count == Q_CNT_W'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/tkre_back.sv */
// ----------------------------------------------------------------------------
// tkre_back
// Executes queued commands: writes the keyword store, reads words out of it
// one character per cycle unless stalled, and drives the registered result port.
// ----------------------------------------------------------------------------
module tkre_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tkre_pkg::t_cmd      i_cmd,
    input  tkre_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tkre_pkg::t_out_item o_out_data
);
    import tkre_pkg::*;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_WORD = 2'b10
    } t_bk_state;

    logic [7:0]        r_store [STORE_DEPTH];
    logic [7:0]        r_rd_data;

    t_bk_state         r_state, n_state;
    logic              r_rd_vld, n_rd_vld;
    logic              r_hold_vld, n_hold_vld;
    logic              r_hold_final, n_hold_final;
    logic [7:0]        r_hold_char, n_hold_char;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [ADDR_W-1:0] r_base, n_base;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              out_free;
    logic              emit;
    t_out_item         emit_data;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              term;
    logic              is_final;
    logic [POS_W-1:0]  next_pos;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign term        = (r_rd_data == NUL_CODE) || (r_rd_data == END_MARK);
    assign is_final    = (r_pos == POS_W'(EMIT_LIMIT - 1));
    assign next_pos    = r_pos + POS_W'(1);

    always_comb begin
        n_state      = r_state;
        n_rd_vld     = r_rd_vld;
        n_hold_vld   = r_hold_vld;
        n_hold_final = r_hold_final;
        n_hold_char  = r_hold_char;
        n_pos        = r_pos;
        n_base       = r_base;
        o_pop        = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = i_cmd.addr;
        emit         = 1'b0;
        emit_data    = '{out_char: r_hold_char, repeat_res: 8'd1, cr_before: 1'b0,
                         end_of_text: 1'b0, last: 1'b0};
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    case (i_cmd.kind)
                        CMD_WRITE: begin
                            o_pop = 1'b1;
                            wr_en = 1'b1;
                        end
                        CMD_EMIT: begin
                            if (out_free) begin
                                o_pop     = 1'b1;
                                emit      = 1'b1;
                                emit_data = '{out_char: i_cmd.ch, repeat_res: i_cmd.rep,
                                              cr_before: i_cmd.cr, end_of_text: i_cmd.eot,
                                              last: 1'b1};
                            end
                        end
                        CMD_WORD: begin
                            o_pop        = 1'b1;
                            rd_en        = 1'b1;
                            n_base       = i_cmd.addr;
                            n_pos        = '0;
                            n_rd_vld     = 1'b1;
                            n_hold_vld   = 1'b0;
                            n_hold_final = 1'b0;
                            n_state      = BK_WORD;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_WORD: begin
                if (r_hold_vld && r_hold_final) begin
                    if (out_free) begin
                        emit           = 1'b1;
                        emit_data.last = 1'b1;
                        n_hold_vld     = 1'b0;
                        n_state        = BK_IDLE;
                    end
                end else if (r_rd_vld && (!r_hold_vld || out_free)) begin
                    emit = r_hold_vld;
                    if (term) begin
                        emit_data.last = 1'b1;
                        n_hold_vld     = 1'b0;
                        n_rd_vld       = 1'b0;
                        n_state        = BK_IDLE;
                    end else begin
                        n_hold_char  = r_rd_data;
                        n_hold_vld   = 1'b1;
                        n_hold_final = is_final;
                        if (is_final) begin
                            n_rd_vld = 1'b0;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_base + ADDR_W'(next_pos);
                            n_pos   = next_pos;
                        end
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[i_cmd.addr] <= i_cmd.ch;
        end
        if (rd_en) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_char <= n_hold_char;
        r_pos       <= n_pos;
        r_base      <= n_base;
        if (emit) begin
            r_out <= emit_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_rd_vld     <= 1'b0;
            r_hold_vld   <= 1'b0;
            r_hold_final <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_vld     <= n_rd_vld;
            r_hold_vld   <= n_hold_vld;
            r_hold_final <= n_hold_final;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/text_keyword_rle_expander.sv */
// ----------------------------------------------------------------------------
// text_keyword_rle_expander
// Expands a compressed text stream with keyword tokens and character runs.
// ----------------------------------------------------------------------------
// A single-result item passes through the command queue and then the output register.
// A keyword token passes the queue, a store read and the hold register before its first
// character is registered, then one character per cycle unless the output stalls; it holds
// the back end (one store read a cycle). A four-entry queue lets the input run ahead of a word.
// Synchronous active-low reset clears the run phase, the queue and the output valid.
// The keyword store is not cleared and must be written before it is read.
module text_keyword_rle_expander (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tkre_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tkre_pkg::t_out_item o_out_data
);
    import tkre_pkg::*;

    logic      w_push;
    logic      w_pop;
    t_cmd      w_push_cmd;
    t_cmd      w_head_cmd;
    t_q_status w_q_status;

    tkre_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    tkre_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    tkre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_head_cmd),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_status.full))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("command popped from an empty queue");

    a_repeat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.repeat_res != 8'd0))
        else $error("result with a zero repeat count");

    a_cr_only_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.cr_before) |-> (o_out_data.out_char == LF_CODE))
        else $error("carriage return flagged on a character other than line feed");

    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.end_of_text) |->
        (o_out_data.last && o_out_data.out_char == EOT_CODE))
        else $error("end of text flagged on a wrong or non-final result");

endmodule
